// ===== rtl/rv32is_pkg.sv =====
// Shared types and constants for the RV32I single-step core.
`default_nettype none
package rv32is_pkg;

  typedef struct packed {
    logic        func;
    logic [18:0] load_address;
    logic [7:0]  load_byte;
  } cmd_t;

  typedef struct packed {
    logic [31:0] next_pc;
    logic        halted;
    logic [7:0]  exit_code;
    logic        reg_written;
    logic [4:0]  reg_index;
    logic [31:0] reg_value;
    logic        illegal_opcode;
  } rsp_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_FETCH,
    ST_EXEC,
    ST_MEMRD,
    ST_RESP
  } st_t;

  localparam logic        FUNC_LOAD  = 1'b0;
  localparam logic [31:0] HALT_WORD  = 32'h0ff00513;

  localparam logic [6:0] OPC_LUI    = 7'b0110111;
  localparam logic [6:0] OPC_AUIPC  = 7'b0010111;
  localparam logic [6:0] OPC_JAL    = 7'b1101111;
  localparam logic [6:0] OPC_JALR   = 7'b1100111;
  localparam logic [6:0] OPC_BRANCH = 7'b1100011;
  localparam logic [6:0] OPC_LOAD   = 7'b0000011;
  localparam logic [6:0] OPC_STORE  = 7'b0100011;
  localparam logic [6:0] OPC_IMM    = 7'b0010011;
  localparam logic [6:0] OPC_REG    = 7'b0110011;

  localparam logic [1:0] WID_BYTE = 2'd0;
  localparam logic [1:0] WID_HALF = 2'd1;
  localparam logic [1:0] WID_WORD = 2'd2;
  localparam logic [1:0] WID_RSVD = 2'd3;

  localparam logic [2:0] BR_EQ  = 3'd0;
  localparam logic [2:0] BR_NE  = 3'd1;
  localparam logic [2:0] BR_LT  = 3'd4;
  localparam logic [2:0] BR_GE  = 3'd5;
  localparam logic [2:0] BR_LTU = 3'd6;
  localparam logic [2:0] BR_GEU = 3'd7;

  localparam logic [2:0] ALU_ADD  = 3'd0;
  localparam logic [2:0] ALU_SLL  = 3'd1;
  localparam logic [2:0] ALU_SLT  = 3'd2;
  localparam logic [2:0] ALU_SLTU = 3'd3;
  localparam logic [2:0] ALU_XOR  = 3'd4;
  localparam logic [2:0] ALU_SR   = 3'd5;
  localparam logic [2:0] ALU_OR   = 3'd6;

  localparam logic [4:0] REG_A0 = 5'd10;

endpackage
`default_nettype wire

// ===== rtl/rv32i_instruction_step.sv =====
// RV32I single-step core: byte memory in four lane RAMs, register file RAM, sequencer.
//
//   channel | signals                      | carries
//   cmd     | cmd_valid, cmd_ready, cmd    | byte load or one instruction step
//   rsp     | rsp_valid, rsp_ready, rsp    | one result per item
//
// A step goes through fetch read, register read and execute; a load adds a data read, which
// goes through the lane RAMs' single port. A byte load or a halted step goes straight
// to the result. A new item is taken in the cycle its predecessor's result moves into
// the output register. After reset the memory is cleared one row of four bytes per
// cycle, with cmd_ready low. MEM_BYTES must be a power of two; the block does not check it.
`default_nettype none
module rv32i_instruction_step #(
  parameter int unsigned MEM_BYTES = 524288
) (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             cmd_valid,
  output logic                  cmd_ready,
  input  wire rv32is_pkg::cmd_t cmd,
  output logic                  rsp_valid,
  input  wire logic             rsp_ready,
  output rv32is_pkg::rsp_t      rsp
);

  localparam int unsigned AW   = $clog2(MEM_BYTES);
  localparam int unsigned ROWS = MEM_BYTES / 4;
  localparam int unsigned RW   = AW - 2;

  rv32is_pkg::st_t  st, st_next;
  rv32is_pkg::rsp_t res;

  logic          clearing;
  logic [RW-1:0] clr_row;
  logic [31:0]   pc;
  logic          halt_seen;
  logic [7:0]    x10_lo;
  logic [31:0]   ir;
  logic [31:0]   rd1, rd2;
  logic [1:0]    ea_off;
  logic [2:0]    ld_f3;
  logic [4:0]    ld_rd;

  logic          accept, out_free;

  // Lane RAM ports
  logic [RW-1:0] lane_addr [4];
  logic [7:0]    lane_wd   [4];
  logic [7:0]    lane_rd   [4];
  logic [3:0]    lane_we, lane_re;
  logic [AW-1:0] acc_base;

  logic [1:0]    rot_off;
  logic [31:0]   rd_word;

  // Register file
  logic [31:0]   rf [32];
  logic [31:0]   rf_valid;
  logic          rf_we;
  logic [4:0]    rf_wa;
  logic [31:0]   rf_wd;

  // Execute stage decode
  logic [6:0]    opc;
  logic [4:0]    rd;
  logic [2:0]    f3;
  logic [31:0]   imm_i, imm_s, imm_b, imm_j, imm_u, ea, cmd_a32;
  logic          ex_wr, ex_illegal, ex_load, ex_store, taken;
  logic [31:0]   ex_val, ex_next, ld_val;

  function automatic logic [31:0] alu(input logic [2:0] fn, input logic sub,
                                      input logic sra, input logic [31:0] a,
                                      input logic [31:0] b);
    logic [31:0] r;
    case (fn)
      rv32is_pkg::ALU_ADD:  r = sub ? a - b : a + b;
      rv32is_pkg::ALU_SLL:  r = a << b[4:0];
      rv32is_pkg::ALU_SLT:  r = {31'd0, $signed(a) < $signed(b)};
      rv32is_pkg::ALU_SLTU: r = {31'd0, a < b};
      rv32is_pkg::ALU_XOR:  r = a ^ b;
      rv32is_pkg::ALU_SR:   r = sra ? 32'($signed(a) >>> b[4:0]) : a >> b[4:0];
      rv32is_pkg::ALU_OR:   r = a | b;
      default:              r = a & b;
    endcase
    return r;
  endfunction

  assign out_free  = !rsp_valid || rsp_ready;
  assign cmd_ready = !clearing &&
                     (st == rv32is_pkg::ST_IDLE || (st == rv32is_pkg::ST_RESP && out_free));
  assign accept    = cmd_valid && cmd_ready;
  assign cmd_a32   = 32'(cmd.load_address);

  // Fetched or loaded bytes come back rotated by the low address bits.
  assign rot_off = (st == rv32is_pkg::ST_FETCH) ? pc[1:0] : ea_off;
  always_comb begin
    for (int k = 0; k < 4; k++) begin
      rd_word[8*k +: 8] = lane_rd[2'(rot_off + 2'(k))];
    end
  end

  assign opc   = ir[6:0];
  assign rd    = ir[11:7];
  assign f3    = ir[14:12];
  assign imm_i = {{20{ir[31]}}, ir[31:20]};
  assign imm_s = {{20{ir[31]}}, ir[31:25], ir[11:7]};
  assign imm_b = {{19{ir[31]}}, ir[31], ir[7], ir[30:25], ir[11:8], 1'b0};
  assign imm_j = {{11{ir[31]}}, ir[31], ir[19:12], ir[20], ir[30:21], 1'b0};
  assign imm_u = {ir[31:12], 12'd0};
  assign ea    = rd1 + ((opc == rv32is_pkg::OPC_STORE) ? imm_s : imm_i);

  always_comb begin
    unique case (f3)
      rv32is_pkg::BR_EQ:  taken = rd1 == rd2;
      rv32is_pkg::BR_NE:  taken = rd1 != rd2;
      rv32is_pkg::BR_LT:  taken = $signed(rd1) < $signed(rd2);
      rv32is_pkg::BR_GE:  taken = !($signed(rd1) < $signed(rd2));
      rv32is_pkg::BR_LTU: taken = rd1 < rd2;
      rv32is_pkg::BR_GEU: taken = rd1 >= rd2;
      default:            taken = 1'b0;
    endcase
  end

  always_comb begin
    ex_wr      = 1'b0;
    ex_val     = '0;
    ex_illegal = 1'b0;
    ex_load    = 1'b0;
    ex_store   = 1'b0;
    ex_next    = pc + 32'd4;
    unique case (opc)
      rv32is_pkg::OPC_LUI: begin
        ex_wr  = 1'b1;
        ex_val = imm_u;
      end
      rv32is_pkg::OPC_AUIPC: begin
        ex_wr  = 1'b1;
        ex_val = pc + imm_u;
      end
      rv32is_pkg::OPC_JAL: begin
        ex_wr   = 1'b1;
        ex_val  = pc + 32'd4;
        ex_next = pc + imm_j;
      end
      rv32is_pkg::OPC_JALR: begin
        ex_wr   = 1'b1;
        ex_val  = pc + 32'd4;
        ex_next = (rd1 + imm_i) & 32'hFFFF_FFFE;
      end
      rv32is_pkg::OPC_BRANCH: begin
        if (taken) ex_next = pc + imm_b;
      end
      rv32is_pkg::OPC_LOAD: begin
        ex_load = f3[1:0] != rv32is_pkg::WID_RSVD;
      end
      rv32is_pkg::OPC_STORE: begin
        ex_store = f3[1:0] != rv32is_pkg::WID_RSVD;
      end
      rv32is_pkg::OPC_IMM: begin
        ex_wr  = 1'b1;
        ex_val = alu(f3, 1'b0, ir[30], rd1, imm_i);
      end
      rv32is_pkg::OPC_REG: begin
        ex_wr  = 1'b1;
        ex_val = alu(f3, ir[30], ir[30], rd1, rd2);
      end
      default: ex_illegal = 1'b1;
    endcase
  end

  always_comb begin
    unique case (ld_f3[1:0])
      rv32is_pkg::WID_BYTE: ld_val = ld_f3[2] ? {24'd0, rd_word[7:0]}
                                              : {{24{rd_word[7]}}, rd_word[7:0]};
      rv32is_pkg::WID_HALF: ld_val = ld_f3[2] ? {16'd0, rd_word[15:0]}
                                              : {{16{rd_word[15]}}, rd_word[15:0]};
      default:              ld_val = rd_word;
    endcase
  end

  always_comb begin
    if (st == rv32is_pkg::ST_MEMRD) begin
      rf_we = ld_rd != 5'd0;
      rf_wa = ld_rd;
      rf_wd = ld_val;
    end else begin
      rf_we = (st == rv32is_pkg::ST_EXEC) && ex_wr && (rd != 5'd0);
      rf_wa = rd;
      rf_wd = ex_val;
    end
  end

  // Next state
  always_comb begin
    st_next = st;
    unique case (st)
      rv32is_pkg::ST_IDLE, rv32is_pkg::ST_RESP: begin
        if (accept) begin
          st_next = (cmd.func == rv32is_pkg::FUNC_LOAD || halt_seen) ?
                    rv32is_pkg::ST_RESP : rv32is_pkg::ST_FETCH;
        end else if (st == rv32is_pkg::ST_RESP && out_free) begin
          st_next = rv32is_pkg::ST_IDLE;
        end
      end
      rv32is_pkg::ST_FETCH: begin
        st_next = (rd_word == rv32is_pkg::HALT_WORD) ? rv32is_pkg::ST_RESP
                                                     : rv32is_pkg::ST_EXEC;
      end
      rv32is_pkg::ST_EXEC:  st_next = ex_load ? rv32is_pkg::ST_MEMRD : rv32is_pkg::ST_RESP;
      rv32is_pkg::ST_MEMRD: st_next = rv32is_pkg::ST_RESP;
      default:              st_next = rv32is_pkg::ST_IDLE;
    endcase
  end

  // Lane RAM control. Lanes below the start offset of a span take the following row.
  always_comb begin
    lane_we  = '0;
    lane_re  = '0;
    acc_base = pc[AW-1:0];
    if (accept && cmd.func == rv32is_pkg::FUNC_LOAD) begin
      acc_base = cmd_a32[AW-1:0];
    end else if (st == rv32is_pkg::ST_EXEC) begin
      acc_base = ea[AW-1:0];
    end
    for (int j = 0; j < 4; j++) begin
      lane_addr[j] = acc_base[AW-1:2] + RW'(2'(j) < acc_base[1:0]);
      lane_wd[j]   = rd2[{2'(2'(j) - acc_base[1:0]), 3'd0} +: 8];
      if (clearing) begin
        lane_addr[j] = clr_row;
        lane_wd[j]   = '0;
        lane_we[j]   = 1'b1;
      end else if (accept) begin
        if (cmd.func == rv32is_pkg::FUNC_LOAD) begin
          lane_we[j] = 2'(j) == acc_base[1:0];
          lane_wd[j] = cmd.load_byte;
        end else begin
          lane_re[j] = !halt_seen;
        end
      end else if (st == rv32is_pkg::ST_EXEC) begin
        lane_re[j] = ex_load;
        unique case (f3[1:0])
          rv32is_pkg::WID_BYTE: lane_we[j] = ex_store && 2'(2'(j) - acc_base[1:0]) == 2'd0;
          rv32is_pkg::WID_HALF: lane_we[j] = ex_store && 2'(2'(j) - acc_base[1:0]) < 2'd2;
          default:              lane_we[j] = ex_store;
        endcase
      end
    end
  end

  for (genvar g = 0; g < 4; g++) begin : g_lane
    logic [7:0] mem [ROWS];
    always_ff @(posedge clk) begin
      if (lane_we[g]) mem[lane_addr[g]] <= lane_wd[g];
      if (lane_re[g]) lane_rd[g] <= mem[lane_addr[g]];
    end
  end

  always_ff @(posedge clk) begin
    if (rf_we) rf[rf_wa] <= rf_wd;
    if (st == rv32is_pkg::ST_FETCH) begin
      rd1 <= rf_valid[rd_word[19:15]] ? rf[rd_word[19:15]] : '0;
      rd2 <= rf_valid[rd_word[24:20]] ? rf[rd_word[24:20]] : '0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      st        <= rv32is_pkg::ST_IDLE;
      clearing  <= 1'b1;
      clr_row   <= '0;
      pc        <= '0;
      halt_seen <= 1'b0;
      x10_lo    <= '0;
      rsp_valid <= 1'b0;
      rf_valid  <= '0;
    end else begin
      st <= st_next;
      if (clearing) begin
        clr_row <= clr_row + RW'(1);
        if (clr_row == RW'(ROWS - 1)) clearing <= 1'b0;
      end
      if (st == rv32is_pkg::ST_RESP && out_free) begin
        rsp       <= res;
        rsp_valid <= 1'b1;
      end else if (rsp_ready) begin
        rsp_valid <= 1'b0;
      end
      if (rf_we) begin
        rf_valid[rf_wa] <= 1'b1;
        if (rf_wa == rv32is_pkg::REG_A0) x10_lo <= rf_wd[7:0];
      end
      if (accept) begin
        res <= '{pc, halt_seen, (halt_seen ? x10_lo : 8'd0), 1'b0, 5'd0, 32'd0, 1'b0};
      end
      unique case (st)
        rv32is_pkg::ST_FETCH: begin
          ir <= rd_word;
          if (rd_word == rv32is_pkg::HALT_WORD) begin
            halt_seen     <= 1'b1;
            res.halted    <= 1'b1;
            res.exit_code <= x10_lo;
          end
        end
        rv32is_pkg::ST_EXEC: begin
          pc                 <= ex_next;
          ea_off             <= ea[1:0];
          ld_f3              <= f3;
          ld_rd              <= rd;
          res.next_pc        <= ex_next;
          res.reg_written    <= rf_we;
          res.reg_index      <= rf_we ? rd : 5'd0;
          res.reg_value      <= rf_we ? ex_val : 32'd0;
          res.illegal_opcode <= ex_illegal;
        end
        rv32is_pkg::ST_MEMRD: begin
          res.reg_written <= rf_we;
          res.reg_index   <= rf_we ? ld_rd : 5'd0;
          res.reg_value   <= rf_we ? ld_val : 32'd0;
        end
        default: ;
      endcase
    end
  end

  a_x0_never_written: assert property (@(posedge clk) disable iff (rst) !rf_valid[0])
    else $error("register x0 marked written");

  a_halt_no_write: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && rsp.halted |-> !rsp.reg_written && !rsp.illegal_opcode)
    else $error("halted result carries a register write");

  a_halted_no_exec: assert property (@(posedge clk) disable iff (rst)
    halt_seen |-> st != rv32is_pkg::ST_EXEC && st != rv32is_pkg::ST_MEMRD)
    else $error("instruction executed after halt");

  a_lane_port: assert property (@(posedge clk) disable iff (rst)
    (lane_we & lane_re) == 4'd0)
    else $error("lane read and write in one cycle");

  a_no_accept_clear: assert property (@(posedge clk) disable iff (rst)
    clearing |-> !(lane_re != 4'd0) && st == rv32is_pkg::ST_IDLE)
    else $error("activity during memory clear");

endmodule
`default_nettype wire

// ===== dv/tb_rv32i_instruction_step.sv =====
// Self-checking testbench for the RV32I single-step core: byte loads, instruction steps, halt.
`default_nettype none
module tb_rv32i_instruction_step;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned MEM_SIZE = 524288;
  localparam logic [6:0] OPC_BAD = 7'h7F;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic cmd_valid = 1'b0;
  logic cmd_ready;
  rv32is_pkg::cmd_t cmd = '0;
  logic rsp_valid;
  logic rsp_ready = 1'b0;
  rv32is_pkg::rsp_t rsp;

  rv32i_instruction_step #(.MEM_BYTES(MEM_SIZE)) dut (
    .clk(clk), .rst(rst),
    .cmd_valid(cmd_valid), .cmd_ready(cmd_ready), .cmd(cmd),
    .rsp_valid(rsp_valid), .rsp_ready(rsp_ready), .rsp(rsp)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Shadow copy of the core's architectural state.
  logic [7:0]  mem_img [MEM_SIZE];
  logic [31:0] gpr_img [32];
  logic [31:0] pc_img = '0;
  logic        halt_img = 1'b0;

  rv32is_pkg::rsp_t pending_rsps[$];
  int   n_items = 0;
  int   n_steps = 0;
  int   n_checked = 0;
  int   n_errors = 0;
  bit   calm = 1'b0;
  bit   no_gaps = 1'b0;
  int   hold_left = 0;

  function automatic logic [31:0] mem_word(logic [31:0] addr, int nbytes);
    logic [31:0] v;
    logic [31:0] ai;
    v = '0;
    for (int i = 0; i < nbytes; i++) begin
      ai = addr + i;
      v |= 32'(mem_img[ai[18:0]]) << (8 * i);
    end
    return v;
  endfunction

  function automatic rv32is_pkg::rsp_t predict_core(rv32is_pkg::cmd_t c);
    rv32is_pkg::rsp_t r;
    logic [31:0] ins, a, b, nxt, val, addr, imm;
    logic [31:0] ai;
    logic [6:0] opc;
    logic [4:0] rd;
    logic [2:0] f3;
    logic alt, wr, ill, tk;
    int nbytes;
    r = '0;
    wr = 1'b0;
    ill = 1'b0;
    val = '0;
    if (c.func == rv32is_pkg::FUNC_LOAD) begin
      mem_img[c.load_address] = c.load_byte;
    end else if (!halt_img) begin
      ins = mem_word(pc_img, 4);
      if (ins == rv32is_pkg::HALT_WORD) begin
        halt_img = 1'b1;
      end else begin
        opc = ins[6:0];
        rd = ins[11:7];
        f3 = ins[14:12];
        alt = ins[30];
        a = gpr_img[ins[19:15]];
        b = gpr_img[ins[24:20]];
        nxt = pc_img + 4;
        imm = {{20{ins[31]}}, ins[31:20]};
        case (opc)
          rv32is_pkg::OPC_LUI: begin
            wr = 1'b1; val = {ins[31:12], 12'h000};
          end
          rv32is_pkg::OPC_AUIPC: begin
            wr = 1'b1; val = pc_img + {ins[31:12], 12'h000};
          end
          rv32is_pkg::OPC_JAL: begin
            wr = 1'b1; val = pc_img + 4;
            nxt = pc_img + {{11{ins[31]}}, ins[31], ins[19:12], ins[20], ins[30:21], 1'b0};
          end
          rv32is_pkg::OPC_JALR: begin
            wr = 1'b1; val = pc_img + 4;
            nxt = (a + imm) & 32'hFFFFFFFE;
          end
          rv32is_pkg::OPC_BRANCH: begin
            case (f3)
              rv32is_pkg::BR_EQ:  tk = (a == b);
              rv32is_pkg::BR_NE:  tk = (a != b);
              rv32is_pkg::BR_LT:  tk = ($signed(a) < $signed(b));
              rv32is_pkg::BR_GE:  tk = !($signed(a) < $signed(b));
              rv32is_pkg::BR_LTU: tk = (a < b);
              rv32is_pkg::BR_GEU: tk = (a >= b);
              default: tk = 1'b0;
            endcase
            if (tk) begin
              nxt = pc_img + {{19{ins[31]}}, ins[31], ins[7], ins[30:25], ins[11:8], 1'b0};
            end
          end
          rv32is_pkg::OPC_LOAD: begin
            addr = a + imm;
            if (f3[1:0] != rv32is_pkg::WID_RSVD) begin
              nbytes = 1 << f3[1:0];
              wr = 1'b1;
              val = mem_word(addr, nbytes);
              if (!f3[2] && f3[1:0] == rv32is_pkg::WID_BYTE) val = {{24{val[7]}}, val[7:0]};
              if (!f3[2] && f3[1:0] == rv32is_pkg::WID_HALF) val = {{16{val[15]}}, val[15:0]};
            end
          end
          rv32is_pkg::OPC_STORE: begin
            addr = a + {{20{ins[31]}}, ins[31:25], ins[11:7]};
            if (f3[1:0] != rv32is_pkg::WID_RSVD) begin
              nbytes = 1 << f3[1:0];
              for (int i = 0; i < nbytes; i++) begin
                ai = addr + i;
                mem_img[ai[18:0]] = b[8*i +: 8];
              end
            end
          end
          rv32is_pkg::OPC_IMM, rv32is_pkg::OPC_REG: begin
            wr = 1'b1;
            if (opc == rv32is_pkg::OPC_IMM) b = imm;
            case (f3)
              rv32is_pkg::ALU_ADD:  val = (opc == rv32is_pkg::OPC_REG && alt) ? a - b : a + b;
              rv32is_pkg::ALU_SLL:  val = a << b[4:0];
              rv32is_pkg::ALU_SLT:  val = {31'b0, $signed(a) < $signed(b)};
              rv32is_pkg::ALU_SLTU: val = {31'b0, a < b};
              rv32is_pkg::ALU_XOR:  val = a ^ b;
              rv32is_pkg::ALU_SR:   val = alt ? 32'($signed(a) >>> b[4:0]) : a >> b[4:0];
              rv32is_pkg::ALU_OR:   val = a | b;
              default:              val = a & b;
            endcase
          end
          default: ill = 1'b1;
        endcase
        if (wr && rd != 5'd0) gpr_img[rd] = val;
        else wr = 1'b0;
        pc_img = nxt;
        r.reg_written = wr;
        r.reg_index = wr ? rd : 5'd0;
        r.reg_value = wr ? val : 32'd0;
        r.illegal_opcode = ill;
      end
    end
    r.next_pc = pc_img;
    r.halted = halt_img;
    r.exit_code = halt_img ? gpr_img[rv32is_pkg::REG_A0][7:0] : 8'd0;
    return r;
  endfunction

  task automatic send_item(rv32is_pkg::cmd_t c);
    int gap;
    if (!calm && !no_gaps && $urandom_range(0, 5) == 0) begin
      gap = $urandom_range(1, 17);
      cmd_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    cmd_valid <= 1'b1;
    cmd <= c;
    @(posedge clk);
    while (!cmd_ready) @(posedge clk);
    pending_rsps.push_back(predict_core(c));
    n_items++;
    if (c.func != rv32is_pkg::FUNC_LOAD) n_steps++;
  endtask

  task automatic release_bus();
    cmd_valid <= 1'b0;
    @(posedge clk);
  endtask

  task automatic load_byte_at(logic [18:0] addr, logic [7:0] data);
    rv32is_pkg::cmd_t c;
    c.func = rv32is_pkg::FUNC_LOAD;
    c.load_address = addr;
    c.load_byte = data;
    send_item(c);
  endtask

  task automatic step_once();
    rv32is_pkg::cmd_t c;
    c = 28'($urandom);
    c.func = ~rv32is_pkg::FUNC_LOAD;
    send_item(c);
  endtask

  // Places the instruction at the current program counter, then executes it.
  task automatic run_instr(logic [31:0] word);
    logic [31:0] ai;
    for (int i = 0; i < 4; i++) begin
      ai = pc_img + i;
      load_byte_at(ai[18:0], word[8*i +: 8]);
    end
    step_once();
  endtask

  function automatic logic [31:0] rand_instr();
    logic [31:0] w;
    logic [6:0] opcs [10];
    opcs = '{rv32is_pkg::OPC_LUI, rv32is_pkg::OPC_AUIPC, rv32is_pkg::OPC_JAL,
             rv32is_pkg::OPC_JALR, rv32is_pkg::OPC_BRANCH, rv32is_pkg::OPC_LOAD,
             rv32is_pkg::OPC_STORE, rv32is_pkg::OPC_IMM, rv32is_pkg::OPC_REG, OPC_BAD};
    do begin
      w = $urandom;
      w[6:0] = opcs[$urandom_range(0, 9)];
      if (w[6:0] == OPC_BAD) w[6:0] = 7'($urandom);
      // Half the memory accesses pick x0 as base (the step below may change it) so loads meet earlier stores.
      if ((w[6:0] == rv32is_pkg::OPC_LOAD || w[6:0] == rv32is_pkg::OPC_STORE) &&
          $urandom_range(0, 1)) begin
        w[19:15] = 5'd0;
        w[31:28] = 4'd0;
      end
      // Keep most source registers in a small set so results feed later operands.
      if ($urandom_range(0, 2) != 0) begin
        w[19:15] = 5'($urandom_range(0, 7));
        w[24:20] = 5'($urandom_range(0, 7));
      end
    end while (w == rv32is_pkg::HALT_WORD);
    return w;
  endfunction

  function automatic logic [31:0] i_type(logic [11:0] imm, logic [4:0] rs1, logic [2:0] f3,
                                         logic [4:0] rd, logic [6:0] opc);
    return {imm, rs1, f3, rd, opc};
  endfunction

  task automatic report(string what, logic [31:0] got, logic [31:0] want);
    $display("%0t: %s got %h, wanted %h", $realtime, what, got, want);
    n_errors++;
  endtask

  // Response checker and receiver-side stalls.
  initial begin
    rv32is_pkg::rsp_t want;
    int stall_left;
    stall_left = 0;
    forever begin
      @(posedge clk);
      if (rsp_valid && rsp_ready) begin
        if (pending_rsps.size() == 0) begin
          report("unexpected item, next_pc", rsp.next_pc, 32'd0);
        end else begin
          want = pending_rsps.pop_front();
          n_checked++;
          if (rsp.next_pc != want.next_pc) report("next_pc", rsp.next_pc, want.next_pc);
          if (rsp.halted != want.halted)
            report("halted", 32'(rsp.halted), 32'(want.halted));
          if (rsp.exit_code != want.exit_code)
            report("exit_code", 32'(rsp.exit_code), 32'(want.exit_code));
          if (rsp.reg_written != want.reg_written)
            report("reg_written", 32'(rsp.reg_written), 32'(want.reg_written));
          if (rsp.reg_index != want.reg_index)
            report("reg_index", 32'(rsp.reg_index), 32'(want.reg_index));
          if (rsp.reg_value != want.reg_value) report("reg_value", rsp.reg_value, want.reg_value);
          if (rsp.illegal_opcode != want.illegal_opcode)
            report("illegal_opcode", 32'(rsp.illegal_opcode), 32'(want.illegal_opcode));
        end
      end
      if (hold_left > 0) begin
        hold_left--;
        rsp_ready <= 1'b0;
      end else if (stall_left > 0) begin
        stall_left--;
        rsp_ready <= 1'b0;
      end else if (!calm && $urandom_range(0, 7) == 0) begin
        stall_left = $urandom_range(0, 16);
        rsp_ready <= 1'b0;
      end else begin
        rsp_ready <= 1'b1;
      end
    end
  end

  task automatic test_byte_loads();
    load_byte_at(19'h00000, 8'h00);
    load_byte_at(19'h7FFFF, 8'hFF);
    load_byte_at(19'h55555, 8'hAA);
    load_byte_at(19'h2AAAA, 8'h55);
    step_once();  // all-zero word decodes as an unknown opcode
  endtask

  task automatic test_each_opcode();
    run_instr({20'hFFFFF, 5'd1, rv32is_pkg::OPC_LUI});
    run_instr({20'h80000, 5'd3, rv32is_pkg::OPC_AUIPC});
    run_instr(i_type(12'hFFF, 5'd0, rv32is_pkg::ALU_ADD, 5'd2, rv32is_pkg::OPC_IMM));
    run_instr(i_type(12'h404, 5'd1, rv32is_pkg::ALU_SR, 5'd4, rv32is_pkg::OPC_IMM));
    run_instr({7'h20, 5'd2, 5'd0, rv32is_pkg::ALU_ADD, 5'd6, rv32is_pkg::OPC_REG});
    run_instr({7'h00, 5'd0, 5'd1, rv32is_pkg::ALU_SLT, 5'd7, rv32is_pkg::OPC_REG});
    run_instr(i_type(12'h005, 5'd2, rv32is_pkg::ALU_ADD, 5'd0, rv32is_pkg::OPC_IMM));
    // Word store at -4 and a word load straddling the top of memory.
    run_instr({7'h7F, 5'd1, 5'd0, 1'b0, rv32is_pkg::WID_WORD, 5'h1C, rv32is_pkg::OPC_STORE});
    run_instr(i_type(12'hFFE, 5'd0, {1'b0, rv32is_pkg::WID_WORD}, 5'd9, rv32is_pkg::OPC_LOAD));
    run_instr(i_type(12'hFFC, 5'd0, {1'b0, rv32is_pkg::WID_BYTE}, 5'd11, rv32is_pkg::OPC_LOAD));
    run_instr(i_type(12'hFFC, 5'd0, {1'b1, rv32is_pkg::WID_HALF}, 5'd12, rv32is_pkg::OPC_LOAD));
    run_instr(i_type(12'h000, 5'd0, {1'b0, rv32is_pkg::WID_RSVD}, 5'd13, rv32is_pkg::OPC_LOAD));
    run_instr({7'h00, 5'd1, 5'd0, 1'b0, rv32is_pkg::WID_RSVD, 5'd0, rv32is_pkg::OPC_STORE});
    run_instr({1'b0, 6'd0, 5'd0, 5'd1, rv32is_pkg::BR_LT, 4'd4, 1'b0, rv32is_pkg::OPC_BRANCH});
    run_instr({1'b0, 6'd0, 5'd0, 5'd0, 3'd2, 4'd4, 1'b0, rv32is_pkg::OPC_BRANCH});
    run_instr({1'b1, 10'h3F0, 1'b1, 8'hFF, 5'd5, rv32is_pkg::OPC_JAL});
    run_instr(i_type(12'h001, 5'd2, 3'd0, 5'd14, rv32is_pkg::OPC_JALR));
    run_instr({25'h0, OPC_BAD});
  endtask

  task automatic test_random_programs(int count);
    rv32is_pkg::cmd_t c;
    for (int k = 0; k < count; k++) begin
      if ($urandom_range(0, 7) == 0) begin
        c = 28'($urandom);
        send_item(c);
      end else begin
        run_instr(rand_instr());
      end
    end
  endtask

  task automatic test_output_backpressure();
    no_gaps = 1'b1;
    hold_left = 300;
    test_random_programs(12);
    no_gaps = 1'b0;
  endtask

  task automatic test_halt();
    run_instr(i_type(12'h1A5, 5'd0, rv32is_pkg::ALU_ADD, rv32is_pkg::REG_A0,
                     rv32is_pkg::OPC_IMM));
    run_instr(rv32is_pkg::HALT_WORD);
    step_once();
    load_byte_at(19'h12345, 8'h3C);
    step_once();
  endtask

  initial begin
    for (int i = 0; i < MEM_SIZE; i++) mem_img[i] = 8'h00;
    for (int i = 0; i < 32; i++) gpr_img[i] = 32'h0;
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    test_byte_loads();
    test_each_opcode();
    test_random_programs(110);
    test_output_backpressure();
    test_random_programs(12);
    calm = 1'b1;
    test_random_programs(8);
    test_halt();
    release_bus();
    while (pending_rsps.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    $display("Sent %0d items (%0d instruction steps), checked %0d results.",
             n_items, n_steps, n_checked);
    $display("Covered every opcode class, memory wrap, output stalls and halt.");
    if (n_errors == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

  initial begin
    #10ms;
    $display("Timed out waiting for the core.");
    $display("Mismatches found");
    $finish;
  end

endmodule
`default_nettype wire

// ===== files.f =====
rtl/rv32is_pkg.sv
rtl/rv32i_instruction_step.sv
dv/tb_rv32i_instruction_step.sv
